// ===== design/scale_candidate_evaluator_assert.svh =====
// assertion macros for the scale candidate evaluator
`ifndef SCALE_CANDIDATE_EVALUATOR_ASSERT_SVH
`define SCALE_CANDIDATE_EVALUATOR_ASSERT_SVH
`ifndef ASSERT_OFF
`define SCE_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
`define SCE_ASSERT_IMP(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define SCE_ASSERT(label, cond)
`define SCE_ASSERT_IMP(label, pre, post)
`endif
`endif

// ===== design/sce_pkg.sv =====
// shared types and constants for the scale candidate evaluator
package sce_pkg;
  localparam int ScaleW = 24;
  localparam int CodeW = 8;
  localparam int MagW = 16;
  localparam int NumW = 35;
  localparam int SqW = 28;
  localparam int ShiftQ = 27;
  localparam int MaxDimDefault = 1024;

  localparam logic [1:0] RegScale = 2'd0;
  localparam logic [1:0] RegMaxCode = 2'd1;
  localparam logic [1:0] RegSearchLow = 2'd2;
  localparam logic [1:0] RegSearchHigh = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CODE = 4'b0010,
    ST_UPD  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  typedef struct packed {
    logic load;     // capture input item
    logic code;     // compute and register the code
    logic upd;      // update accumulators and best coordinates
    logic emit;     // load output register and clear
  } cmd_t;

  typedef struct packed {
    logic last;
  } sts_t;
endpackage

// ===== design/scale_candidate_evaluator.sv =====
// top level of the scale candidate evaluator
// Evaluates one candidate scale against a streamed vector of Q1.15 magnitudes.
// Each accepted item goes through capture, code and accumulate states, set by the
// controller sequence around the single code multiplier; after the item marked
// tlast the result register is loaded once it is free, and it then waits for the
// consumer while the next vector may already start. Write configuration only
// while idle. Sums saturate at all ones; they cannot for up to 1024 items, the default MAX_DIM.
module scale_candidate_evaluator #(
  parameter int MAX_DIM = sce_pkg::MaxDimDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // magnitude
  input  logic        in_tlast,   // is_last
  output logic        out_tvalid,
  input  logic        out_tready,
  // numerator_twice[34:0], square_sum_four[62:35], enter_code[70:63],
  // enter_magnitude[86:71], enter_is_start[87], leave_code[95:88],
  // leave_magnitude[111:96], leave_is_end[112], zero fill to 120
  output logic [119:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  import sce_pkg::*;
  localparam int DimW = $clog2(MAX_DIM + 1);
  cmd_t cmd;
  sts_t sts;
  logic busy, in_fire, out_vld_r;
  logic [DimW-1:0] cnt_r;  // item count in the current vector
  logic [ScaleW-1:0] scale_r, slow_r, shigh_r;
  logic [CodeW-1:0] maxc_r;
  logic [NumW-1:0] o_num;
  logic [SqW-1:0] o_sq;
  logic [CodeW-1:0] o_ec, o_lc;
  logic [MagW-1:0] o_em, o_lm;
  logic o_es, o_le;

  assign in_tready = !busy;
  assign in_fire = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  // result register is free when empty or being taken
  wire out_free = !out_vld_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= 24'd4096; maxc_r <= 8'd15; slow_r <= '0; shigh_r <= '1;
      out_vld_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          RegScale: scale_r <= cfg_data;
          RegMaxCode: maxc_r <= cfg_data[CodeW-1:0];
          RegSearchLow: slow_r <= cfg_data;
          RegSearchHigh: shigh_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.emit) out_vld_r <= 1'b1;
      else if (out_tready) out_vld_r <= 1'b0;
      if (in_fire) cnt_r <= in_tlast ? '0 : cnt_r + 1'b1;
    end
  end

  sce_ctrl u_ctrl (.clk, .rst_n, .in_fire, .out_free, .sts, .busy, .cmd);

  sce_dp u_dp (
    .clk, .rst_n, .cmd, .sts, .in_mag(in_tdata), .in_last(in_tlast),
    .scale(scale_r), .code_limit(maxc_r), .search_low(slow_r), .search_high(shigh_r),
    .o_num, .o_sq, .o_ecode(o_ec), .o_emag(o_em), .o_estart(o_es),
    .o_lcode(o_lc), .o_lmag(o_lm), .o_lend(o_le)
  );

  assign out_tvalid = out_vld_r;
  assign out_tdata = {7'd0, o_le, o_lm, o_lc, o_es, o_em, o_ec, o_sq, o_num};

`include "scale_candidate_evaluator_assert.svh"
  `SCE_ASSERT(a_no_in_busy, !(in_fire && busy))
  `SCE_ASSERT_IMP(a_emit_vld, cmd.emit, out_tvalid)
  `SCE_ASSERT(a_cnt_bound, cnt_r <= DimW'(MAX_DIM))
endmodule

// ===== design/sce_ctrl.sv =====
// controller state machine for the scale candidate evaluator
module sce_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_fire,
  input  logic            out_free,
  input  sce_pkg::sts_t   sts,
  output logic            busy,
  output sce_pkg::cmd_t   cmd
);
  import sce_pkg::*;
  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          cmd.load = 1'b1;
          state_nxt = ST_CODE;
        end
      end
      ST_CODE: begin
        cmd.code = 1'b1;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        cmd.upd = 1'b1;
        state_nxt = sts.last ? ST_OUT : ST_IDLE;
      end
      ST_OUT: begin
        if (out_free) begin
          cmd.emit = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

`include "scale_candidate_evaluator_assert.svh"
  `SCE_ASSERT_IMP(a_load_code, cmd.load, state_r == ST_CODE)
  `SCE_ASSERT_IMP(a_code_upd, state_r == ST_CODE, state_r == ST_UPD)
  `SCE_ASSERT(a_one_cmd, $onehot0(cmd))
endmodule

// ===== design/sce_dp.sv =====
// datapath: coding, accumulation, best ratio tracking, result register
module sce_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  sce_pkg::cmd_t                cmd,
  output sce_pkg::sts_t                sts,
  input  logic [sce_pkg::MagW-1:0]     in_mag,
  input  logic                         in_last,
  input  logic [sce_pkg::ScaleW-1:0]   scale,
  input  logic [sce_pkg::CodeW-1:0]    code_limit,
  input  logic [sce_pkg::ScaleW-1:0]   search_low,
  input  logic [sce_pkg::ScaleW-1:0]   search_high,
  output logic [sce_pkg::NumW-1:0]     o_num,
  output logic [sce_pkg::SqW-1:0]      o_sq,
  output logic [sce_pkg::CodeW-1:0]    o_ecode,
  output logic [sce_pkg::MagW-1:0]     o_emag,
  output logic                         o_estart,
  output logic [sce_pkg::CodeW-1:0]    o_lcode,
  output logic [sce_pkg::MagW-1:0]     o_lmag,
  output logic                         o_lend
);
  import sce_pkg::*;
  logic [MagW-1:0] mag_r;
  logic last_r;
  logic [CodeW-1:0] code_r;
  logic [ScaleW+MagW-1:0] prod;
  logic [CodeW-1:0] code_c;
  logic [CodeW+MagW:0] mterm;
  logic [2*CodeW+1:0] sq_term;
  logic [CodeW+MagW:0] e_lhs, e_rhs, l_lhs, l_rhs;
  logic [NumW-1:0] num_r;
  logic [SqW-1:0] sqacc_r;
  logic [NumW:0] num_sum;
  logic [SqW:0] sq_sum;
  logic [CodeW-1:0] ebc_r, lbc_r;
  logic [MagW-1:0] ebm_r, lbm_r;
  logic ef_r, lf_r;
  logic [ScaleW+MagW-1:0] e_clip_l, l_clip_l;
  logic [CodeW+ShiftQ:0] e_clip_r, l_clip_r;
  logic [CodeW:0] odd;

  assign prod = (ScaleW+MagW)'(scale) * (ScaleW+MagW)'(mag_r);
  assign code_c = (prod[ScaleW+MagW-1:ShiftQ] > {5'd0, code_limit}) ? code_limit
                  : prod[ShiftQ+CodeW-1:ShiftQ];
  assign sts.last = last_r;
  assign odd = {code_r, 1'b1};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag_r <= in_mag;
      last_r <= in_last;
    end
    if (cmd.code) begin
      code_r <= code_c;
    end
  end

  // products for update, one multiplier each, from registered code
  assign e_lhs = (CodeW+MagW+1)'(code_r) * (CodeW+MagW+1)'(ebm_r);
  assign e_rhs = (CodeW+MagW+1)'(ebc_r) * (CodeW+MagW+1)'(mag_r);
  assign l_lhs = (CodeW+MagW+1)'({1'b0, code_r} + 9'd1) * (CodeW+MagW+1)'(lbm_r);
  assign l_rhs = (CodeW+MagW+1)'({1'b0, lbc_r} + 9'd1) * (CodeW+MagW+1)'(mag_r);
  assign mterm = (CodeW+MagW+1)'(odd) * (CodeW+MagW+1)'(mag_r);
  assign sq_term = (2*CodeW+2)'(odd) * (2*CodeW+2)'(odd);
  assign num_sum = {1'b0, num_r} + {{(NumW-CodeW-MagW){1'b0}}, mterm};
  assign sq_sum = {1'b0, sqacc_r} + {{(SqW-2*CodeW-1){1'b0}}, sq_term};

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.emit) begin
      num_r <= '0; sqacc_r <= '0;
      ebc_r <= '0; ebm_r <= '0; ef_r <= 1'b0;
      lbc_r <= '0; lbm_r <= '0; lf_r <= 1'b0;
    end else if (cmd.upd) begin
      num_r <= num_sum[NumW] ? '1 : num_sum[NumW-1:0];
      sqacc_r <= sq_sum[SqW] ? '1 : sq_sum[SqW-1:0];
      if (code_r != '0 && (!ef_r || e_lhs > e_rhs)) begin
        ebc_r <= code_r; ebm_r <= mag_r; ef_r <= 1'b1;
      end
      if (code_r < code_limit && mag_r != '0 && (!lf_r || l_lhs < l_rhs)) begin
        lbc_r <= code_r; lbm_r <= mag_r; lf_r <= 1'b1;
      end
    end
  end

  assign e_clip_l = (ScaleW+MagW)'(search_low) * (ScaleW+MagW)'(ebm_r);
  assign l_clip_l = (ScaleW+MagW)'(search_high) * (ScaleW+MagW)'(lbm_r);
  assign e_clip_r = {1'b0, ebc_r, {ShiftQ{1'b0}}};
  assign l_clip_r = {({1'b0, lbc_r} + 9'd1), {ShiftQ{1'b0}}};

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      o_num <= num_r;
      o_sq <= sqacc_r;
      o_ecode <= ebc_r;
      o_emag <= ebm_r;
      o_estart <= !ef_r || (e_clip_l > {4'd0, e_clip_r});
      o_lcode <= lbc_r;
      o_lmag <= lbm_r;
      o_lend <= !lf_r || (l_clip_l < {4'd0, l_clip_r});
    end
  end

`include "scale_candidate_evaluator_assert.svh"
  `SCE_ASSERT(a_code_max, !cmd.upd || code_r <= code_limit)
  `SCE_ASSERT_IMP(a_clear, cmd.emit, num_r == '0 && !ef_r && !lf_r)
endmodule

// ===== tb/scale_candidate_evaluator_checker.sv =====
// checker: watches the channels, predicts vector results and compares them
`timescale 1ns / 1ps
module scale_candidate_evaluator_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [15:0]  in_tdata,
  input  logic         in_tlast,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [119:0] out_tdata,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [23:0]  cfg_data,
  output int           fail_count,
  output int           pending_count
);
  import sce_pkg::*;

  // packed from the top bit down, matching the result transaction layout
  typedef struct packed {
    logic        leave_end_q;
    logic [15:0] leave_mag_q;
    logic [7:0]  leave_code_q;
    logic        enter_start_q;
    logic [15:0] enter_mag_q;
    logic [7:0]  enter_code_q;
    logic [27:0] sq_q;
    logic [34:0] num_q;
  } vec_result_t;

  vec_result_t result_queue[$];

  logic [23:0] scale_r, low_r, high_r;
  logic [7:0]  maxc_r;
  logic [34:0] num_acc;
  logic [27:0] sq_acc;
  logic [7:0]  ent_code, lv_code;
  logic [15:0] ent_mag, lv_mag;
  logic        ent_found, lv_found;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  task automatic predict_item(input logic [15:0] m, input logic last);
    logic [63:0] code, odd, s, lhs, rhs;
    vec_result_t r;
    code = (64'(scale_r) * m) >> ShiftQ;
    if (code > maxc_r) code = maxc_r;
    odd = 2 * code + 1;
    s = num_acc + m * odd;
    num_acc = (s > 64'h7_FFFF_FFFF) ? '1 : s[34:0];
    s = sq_acc + odd * odd;
    sq_acc = (s > 64'hFFF_FFFF) ? '1 : s[27:0];
    if (code > 0 && (!ent_found || code * ent_mag > ent_code * m)) begin
      ent_code = code[7:0]; ent_mag = m; ent_found = 1;
    end
    if (code < maxc_r && m > 0 &&
        (!lv_found || (code + 1) * lv_mag < (64'(lv_code) + 1) * m)) begin
      lv_code = code[7:0]; lv_mag = m; lv_found = 1;
    end
    if (last) begin
      r = '0;
      r.num_q = num_acc;
      r.sq_q = sq_acc;
      r.enter_start_q = 1;
      r.leave_end_q = 1;
      if (ent_found) begin
        lhs = 64'(low_r) * ent_mag;
        rhs = 64'(ent_code) << ShiftQ;
        r.enter_code_q = ent_code; r.enter_mag_q = ent_mag;
        r.enter_start_q = lhs > rhs;
      end
      if (lv_found) begin
        lhs = 64'(high_r) * lv_mag;
        rhs = (64'(lv_code) + 1) << ShiftQ;
        r.leave_code_q = lv_code; r.leave_mag_q = lv_mag;
        r.leave_end_q = lhs < rhs;
      end
      result_queue.push_back(r);
      num_acc = 0; sq_acc = 0; ent_code = 0; ent_mag = 0; ent_found = 0;
      lv_code = 0; lv_mag = 0; lv_found = 0;
    end
  endtask

  initial begin
    fail_count = 0;
    scale_r = 4096; maxc_r = 15; low_r = 0; high_r = 24'hFFFFFF;
    num_acc = 0; sq_acc = 0; ent_code = 0; ent_mag = 0; ent_found = 0;
    lv_code = 0; lv_mag = 0; lv_found = 0;
  end

  always @(posedge clk) begin
    vec_result_t got, want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          RegScale:      scale_r = cfg_data;
          RegMaxCode:    maxc_r = cfg_data[7:0];
          RegSearchLow:  low_r = cfg_data;
          RegSearchHigh: high_r = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) predict_item(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        got = out_tdata[112:0];
        if (result_queue.size() == 0) begin
          report("unexpected result", got.num_q, 0);
        end else begin
          want = result_queue.pop_front();
          if (got.num_q != want.num_q) report("numerator_twice", got.num_q, want.num_q);
          if (got.sq_q != want.sq_q) report("square_sum_four", got.sq_q, want.sq_q);
          if (got.enter_code_q != want.enter_code_q)
            report("enter_code", got.enter_code_q, want.enter_code_q);
          if (got.enter_mag_q != want.enter_mag_q)
            report("enter_magnitude", got.enter_mag_q, want.enter_mag_q);
          if (got.enter_start_q != want.enter_start_q)
            report("enter_is_start", got.enter_start_q, want.enter_start_q);
          if (got.leave_code_q != want.leave_code_q)
            report("leave_code", got.leave_code_q, want.leave_code_q);
          if (got.leave_mag_q != want.leave_mag_q)
            report("leave_magnitude", got.leave_mag_q, want.leave_mag_q);
          if (got.leave_end_q != want.leave_end_q)
            report("leave_is_end", got.leave_end_q, want.leave_end_q);
        end
      end
    end
    pending_count = result_queue.size();
  end
endmodule

// ===== tb/scale_candidate_evaluator_tb.sv =====
// testbench top: stimulus, configuration phases and verdict
`timescale 1ns / 1ps
module scale_candidate_evaluator_tb;
  import sce_pkg::*;

  localparam int CycleLimit = 400000;

  logic         clk, rst_n;
  logic         in_tvalid, in_tready, in_tlast;
  logic [15:0]  in_tdata;
  logic         out_tvalid, out_tready;
  logic [119:0] out_tdata;
  logic         cfg_valid, cfg_ready;
  logic [1:0]   cfg_index;
  logic [23:0]  cfg_data;
  int           fail_count, pending_count;
  int           cycle_count;
  bit           no_idle;     // stretch with no idling on either side
  bit           hold_sink;   // long receiver hold-off

  scale_candidate_evaluator dut (.*);

  scale_candidate_evaluator_checker u_chk (.*);

  always begin
    clk = 0; #5;
    clk = 1; #5;
  end

  // timeout guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: random stalls, long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 0;
    else if (hold_sink) out_tready <= 0;
    else out_tready <= no_idle || ($urandom_range(99) >= 12);
  end

  // one input transaction, with random gaps before it; valid stays up after it
  task automatic send_item(input logic [15:0] m, input logic last);
    while (!no_idle && $urandom_range(99) < 12) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1; in_tdata <= m; in_tlast <= last;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] v);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // stop sending, wait for all results, then let the pipeline settle
  task automatic drain;
    in_tvalid <= 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_config(input logic [23:0] s, input logic [7:0] mc,
                            input logic [23:0] lo, input logic [23:0] hi);
    drain();
    write_reg(RegScale, s);
    write_reg(RegMaxCode, {16'd0, mc});
    write_reg(RegSearchLow, lo);
    write_reg(RegSearchHigh, hi);
    cfg_valid <= 0;
  endtask

  // random magnitude, mostly full range, sometimes extremes
  function automatic logic [15:0] rand_mag;
    case ($urandom_range(9))
      0: rand_mag = 0;
      1: rand_mag = 16'hFFFF;
      2: rand_mag = 16'($urandom_range(15));
      default: rand_mag = 16'($urandom);
    endcase
  endfunction

  function automatic logic [23:0] rand_scale;
    case ($urandom_range(5))
      0: rand_scale = 24'hFFFFFF;
      1: rand_scale = 0;
      2: rand_scale = 24'($urandom_range(4096, 1));
      default: rand_scale = 24'($urandom_range(200000));
    endcase
  endfunction

  initial begin
    int sent, len;
    rst_n = 0; in_tvalid = 0; in_tdata = 0; in_tlast = 0;
    cfg_valid = 0; cfg_index = 0; cfg_data = 0;
    no_idle = 0; hold_sink = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: reset config, extremes, zero magnitude, ties, single item vectors
    send_item(16'h0000, 1);
    send_item(16'hFFFF, 1);
    send_item(16'h4000, 0); send_item(16'h4000, 0); send_item(16'h0000, 0);
    send_item(16'h8000, 0); send_item(16'h0001, 1);
    send_item(16'h2000, 0); send_item(16'h4000, 1);  // both items code to zero under the reset scale
    set_config(24'hFFFFFF, 8'd255, 24'd0, 24'hFFFFFF);
    send_item(16'hFFFF, 0); send_item(16'h0001, 0); send_item(16'h0000, 1);
    set_config(24'd0, 8'd1, 24'hFFFFFF, 24'd0);
    send_item(16'h1234, 0); send_item(16'hFFFF, 1);
    set_config(24'd20000, 8'd1, 24'd3000, 24'd5000);
    send_item(16'h7000, 0); send_item(16'h3000, 0); send_item(16'h0100, 1);
    set_config(24'd50000, 8'd255, 24'd40000, 24'd60000);
    send_item(16'h8000, 0); send_item(16'h0123, 0); send_item(16'hABCD, 1);

    // random phases: short vectors with random content
    sent = 0;
    for (int ph = 0; ph < 12; ph++) begin
      set_config(rand_scale(), 8'($urandom_range(255, 1)), 24'($urandom), 24'($urandom));
      if (ph == 3) no_idle = 1;
      if (ph == 5) no_idle = 0;
      for (int v = 0; v < 30; v++) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(40, 1) : $urandom_range(6, 1);
        if (ph == 7 && v == 4) begin
          // receiver holds off while the sender keeps going
          fork
            begin hold_sink = 1; repeat (300) @(posedge clk); hold_sink = 0; end
          join_none
        end
        for (int k = 0; k < len; k++) begin
          send_item(rand_mag(), k == len - 1);
          sent++;
        end
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
